// File: hdl/pcws_pkg.sv
// Package with shared types, constants and helpers for the packet classifier.
`default_nettype none
package pcws_pkg;

   localparam int unsigned MaxWorkerQueues   = 16;
   localparam int unsigned RadiusServerSlots = 4;

   localparam logic [15:0] EtypeVlan   = 16'h8100;
   localparam logic [15:0] EtypeQinq   = 16'h88A8;
   localparam logic [15:0] EtypeIpv4   = 16'h0800;
   localparam logic [15:0] EtypePppoeD = 16'h8863;
   localparam logic [15:0] EtypePppoeS = 16'h8864;
   localparam logic [15:0] PortAuth    = 16'd1812;
   localparam logic [15:0] PortAcct    = 16'd1813;
   localparam logic [15:0] PortCoa     = 16'd3799;
   localparam logic [31:0] HashMult    = 32'd2654435761;

   localparam logic [2:0] CsrWorkerCount  = 3'd0;
   localparam logic [2:0] CsrRadiusEnable = 3'd1;
   localparam logic [2:0] CsrPppoeEnable  = 3'd2;
   localparam logic [2:0] CsrServerCount  = 3'd3;

   typedef enum logic [2:0] {
      PH_ETH     = 3'd0,
      PH_TAG     = 3'd1,
      PH_IP      = 3'd2,
      PH_IP_DONE = 3'd3,
      PH_OTHER   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CLS_INVALID = 2'd0,
      CLS_PPPOE   = 2'd1,
      CLS_RADIUS  = 2'd2,
      CLS_USER    = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      DEST_DROP   = 2'd0,
      DEST_RADIUS = 2'd1,
      DEST_PPPOE  = 2'd2,
      DEST_WORKER = 2'd3
   } dest_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_MULT = 2'd1,
      BK_MOD  = 2'd2,
      BK_OUT  = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        frame_end;
      logic        rss_valid;
      logic [31:0] rss_value;
   } req_type;

   typedef struct packed {
      logic [1:0] destination;
      logic [1:0] frame_class;
      logic [3:0] worker_index;
   } rsp_type;

   // Per-frame summary handed from the parser to the dispatcher.
   typedef struct packed {
      class_type   frame_class;
      logic        use_rss;
      logic        hash_zero;
      logic [31:0] rss_value;
      logic [31:0] hash_key;
      logic        radius_en;
      logic        pppoe_en;
      logic [4:0]  worker_count;
   } job_type;

   function automatic logic is_tag(input logic [15:0] et);
      return (et == EtypeVlan) || (et == EtypeQinq);
   endfunction

   function automatic phase_type phase_after_l2(input logic [15:0] et);
      if (is_tag(et)) return PH_TAG;
      if (et == EtypeIpv4) return PH_IP;
      return PH_OTHER;
   endfunction

   function automatic logic radius_port(input logic [15:0] p);
      return (p == PortAuth) || (p == PortAcct) || (p == PortCoa);
   endfunction

endpackage
`default_nettype wire

// File: hdl/pcws_front.sv
// Byte parser: tracks headers of one frame and builds a per-frame job.
`default_nettype none
module pcws_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pcws_pkg::req_type req_data,
   input  wire logic [4:0]       worker_count,
   input  wire logic             radius_en,
   input  wire logic             pppoe_en,
   input  wire logic [2:0]       server_count,
   input  wire logic [127:0]     servers,
   output logic                  job_valid,
   output pcws_pkg::job_type     job_data,
   input  wire logic             job_full
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] et_ff, et_in;
   logic [15:0] nhs_ff, nhs_in;
   logic [31:0] tw_ff, tw_in;
   pcws_pkg::phase_type ph_ff, ph_in;
   logic [7:0]  hdr_ff [20];
   logic        hdr_we;
   logic [4:0]  hdr_idx;
   logic        accept;
   logic [7:0]  b;
   logic [15:0] rel;
   logic [3:0]  ihl_now;
   logic [16:0] tstart;
   logic [16:0] pos_x;
   logic [16:0] len;
   logic [16:0] nhs20;
   logic [31:0] sa_be, da_be, sa_le, da_le;
   logic [15:0] sp_be, dp_be, sp_le, dp_le;
   logic        sa_hit, da_hit, is_radius, ports_ok;
   pcws_pkg::class_type cls;
   logic [2:0]  nsrv;

   assign req_stall = job_full;
   assign accept    = req_valid && !job_full;
   assign b         = req_data.frame_byte;
   assign rel       = pos_ff - nhs_ff;

   // The first IPv4 header byte carries the header length; use it on the byte it arrives.
   assign ihl_now   = (ph_ff == pcws_pkg::PH_IP && rel == 16'd0) ? b[3:0] : hdr_ff[0][3:0];
   assign tstart    = {1'b0, nhs_ff} + {11'd0, ihl_now, 2'b00};
   assign pos_x     = {1'b0, pos_ff};

   // Parser next-state logic for one byte.
   always_comb begin
      pos_in  = pos_ff;
      et_in   = et_ff;
      nhs_in  = nhs_ff;
      tw_in   = tw_ff;
      ph_in   = ph_ff;
      hdr_we  = 1'b0;
      hdr_idx = rel[4:0];
      if (pos_ff != 16'hFFFF) begin
         pos_in = pos_ff + 16'd1;
         unique case (ph_ff)
            pcws_pkg::PH_ETH: begin
               if (pos_ff == 16'd12) begin
                  et_in = {b, 8'h00};
               end else if (pos_ff == 16'd13) begin
                  et_in = {et_ff[15:8], b};
                  ph_in = pcws_pkg::phase_after_l2({et_ff[15:8], b});
               end
            end
            pcws_pkg::PH_TAG: begin
               if (rel == 16'd2) begin
                  tw_in = {24'd0, b};
               end else if (rel == 16'd3) begin
                  et_in  = {tw_ff[7:0], b};
                  tw_in  = '0;
                  nhs_in = nhs_ff + 16'd4;
                  ph_in  = pcws_pkg::phase_after_l2({tw_ff[7:0], b});
               end
            end
            pcws_pkg::PH_IP: begin
               hdr_we = (rel < 16'd20);
               if (rel >= 16'd19) ph_in = pcws_pkg::PH_IP_DONE;
            end
            default: ;
         endcase
         if ((ph_ff == pcws_pkg::PH_IP || ph_ff == pcws_pkg::PH_IP_DONE) &&
             pos_x >= tstart && pos_x < tstart + 17'd4) begin
            tw_in = {tw_ff[23:0], b};
         end
      end
   end

   // Frame-end classification uses the state after this byte.
   assign len   = {1'b0, pos_in};
   assign nhs20 = {1'b0, nhs_in} + 17'd20;

   always_comb begin
      logic [7:0] h [20];
      logic [16:0] t;
      for (int i = 0; i < 20; i++) h[i] = hdr_ff[i];
      if (hdr_we) h[hdr_idx] = b;
      t     = {1'b0, nhs_in} + {11'd0, h[0][3:0], 2'b00};
      sa_be = {h[12], h[13], h[14], h[15]};
      da_be = {h[16], h[17], h[18], h[19]};
      sa_le = {h[15], h[14], h[13], h[12]};
      da_le = {h[19], h[18], h[17], h[16]};
      sp_be = tw_in[31:16];
      dp_be = tw_in[15:0];
      sp_le = {tw_in[23:16], tw_in[31:24]};
      dp_le = {tw_in[7:0], tw_in[15:8]};
      ports_ok = (t + 17'd4 <= len);
      nsrv = (server_count > 3'(pcws_pkg::RadiusServerSlots)) ?
             3'(pcws_pkg::RadiusServerSlots) : server_count;
      sa_hit = 1'b0;
      da_hit = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < nsrv) begin
            if (servers[i*32 +: 32] == sa_be) sa_hit = 1'b1;
            if (servers[i*32 +: 32] == da_be) da_hit = 1'b1;
         end
      end
      is_radius = (h[9] == 8'd17) && (t + 17'd8 <= len) &&
                  (pcws_pkg::radius_port(sp_be) || pcws_pkg::radius_port(dp_be)) &&
                  (sa_hit || da_hit);
      priority if (len < 17'd14) cls = pcws_pkg::CLS_INVALID;
      else if (et_in == pcws_pkg::EtypePppoeD || et_in == pcws_pkg::EtypePppoeS)
         cls = pcws_pkg::CLS_PPPOE;
      else if (et_in != pcws_pkg::EtypeIpv4) cls = pcws_pkg::CLS_USER;
      else if (nhs20 > len) cls = pcws_pkg::CLS_INVALID;
      else if (is_radius) cls = pcws_pkg::CLS_RADIUS;
      else cls = pcws_pkg::CLS_USER;

      job_data.frame_class  = cls;
      job_data.use_rss      = req_data.rss_valid;
      job_data.rss_value    = req_data.rss_value;
      job_data.hash_zero    = (et_in != pcws_pkg::EtypeIpv4) || (len < 17'd34) ||
                              (nhs20 > len);
      job_data.hash_key     = (sa_le ^ da_le) ^
                              {(ports_ok ? (sp_le ^ dp_le) : 16'd0), 16'd0};
      job_data.radius_en    = radius_en;
      job_data.pppoe_en     = pppoe_en;
      job_data.worker_count = worker_count;
   end

   assign job_valid = accept && req_data.frame_end;

   // Header byte store; read only after it has been written in a frame.
   always_ff @(posedge clock) begin
      if (accept && hdr_we) hdr_ff[hdr_idx] <= b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         et_ff  <= '0;
         nhs_ff <= 16'd14;
         tw_ff  <= '0;
         ph_ff  <= pcws_pkg::PH_ETH;
      end else if (accept) begin
         if (req_data.frame_end) begin
            pos_ff <= '0;
            et_ff  <= '0;
            nhs_ff <= 16'd14;
            tw_ff  <= '0;
            ph_ff  <= pcws_pkg::PH_ETH;
         end else begin
            pos_ff <= pos_in;
            et_ff  <= et_in;
            nhs_ff <= nhs_in;
            tw_ff  <= tw_in;
            ph_ff  <= ph_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: hdl/pcws_queue.sv
// Two-entry job queue between the parser and the dispatcher.
`default_nettype none
module pcws_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pcws_pkg::job_type push_data,
   output logic                   full,
   output logic                   not_empty,
   output pcws_pkg::job_type      head,
   input  wire logic              pop
);

   pcws_pkg::job_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rp_ff];

   // Pointer and count update.
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/pcws_back.sv
// Dispatcher: hashes the key or takes the RSS value, reduces modulo the worker count and emits the result.
`default_nettype none
module pcws_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_ready,
   input  wire pcws_pkg::job_type job,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pcws_pkg::rsp_type      rsp_data
);

   pcws_pkg::back_state_type st_ff, st_in;
   pcws_pkg::job_type job_ff;
   logic [31:0] rem_ff, rem_in;
   logic [4:0]  n_ff;
   logic [5:0]  step_ff, step_in;
   logic [31:0] prod;
   logic [4:0]  nsat;
   logic        load;
   logic [1:0]  dest;
   logic [3:0]  widx;

   assign nsat = (job.worker_count > 5'(pcws_pkg::MaxWorkerQueues)) ?
                 5'(pcws_pkg::MaxWorkerQueues) : job.worker_count;
   assign prod = job_ff.hash_key * pcws_pkg::HashMult;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         pcws_pkg::BK_IDLE: if (job_ready) st_in = pcws_pkg::BK_MULT;
         pcws_pkg::BK_MULT: st_in = pcws_pkg::BK_MOD;
         pcws_pkg::BK_MOD:  if (step_ff == 6'd0) st_in = pcws_pkg::BK_OUT;
         pcws_pkg::BK_OUT:  if (!rsp_stall) st_in = pcws_pkg::BK_IDLE;
         default:           st_in = pcws_pkg::BK_IDLE;
      endcase
   end

   // Outputs and datapath controls.
   always_comb begin
      load      = (st_ff == pcws_pkg::BK_IDLE) && job_ready;
      job_pop   = load;
      rsp_valid = (st_ff == pcws_pkg::BK_OUT);
   end

   // Long division of the 32-bit value by the worker count, MSB first.
   logic [31:0] dvd_ff, dvd_in;
   always_comb begin
      logic [37:0] r;
      r       = '0;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      step_in = step_ff;
      if (st_ff == pcws_pkg::BK_MULT) begin
         dvd_in  = job_ff.use_rss ? job_ff.rss_value :
                   (job_ff.hash_zero ? 32'd0 : prod);
         rem_in  = '0;
         step_in = 6'd32;
      end else if (st_ff == pcws_pkg::BK_MOD && step_ff != 6'd0) begin
         r = {5'd0, rem_ff[31:0], dvd_ff[31]};
         if (r >= {33'd0, n_ff}) r = r - {33'd0, n_ff};
         rem_in  = r[31:0];
         dvd_in  = {dvd_ff[30:0], 1'b0};
         step_in = step_ff - 6'd1;
      end
   end

   // Final routing decision.
   always_comb begin
      dest = pcws_pkg::DEST_DROP;
      widx = '0;
      if (job_ff.frame_class == pcws_pkg::CLS_RADIUS && job_ff.radius_en)
         dest = pcws_pkg::DEST_RADIUS;
      else if (job_ff.frame_class == pcws_pkg::CLS_PPPOE && job_ff.pppoe_en)
         dest = pcws_pkg::DEST_PPPOE;
      else if (job_ff.frame_class != pcws_pkg::CLS_INVALID && n_ff != 5'd0) begin
         dest = pcws_pkg::DEST_WORKER;
         widx = rem_ff[3:0];
      end
      rsp_data.destination  = dest;
      rsp_data.frame_class  = job_ff.frame_class;
      rsp_data.worker_index = widx;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
         n_ff   <= nsat;
      end
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= pcws_pkg::BK_IDLE;
      else       st_ff <= st_in;
   end

endmodule
`default_nettype wire

// File: hdl/packet_classify_and_worker_select_core.sv
// Top level of the packet classifier and worker selector.
// Throughput: one byte per cycle, stalled via req_stall while the job queue is
// full; the bit-serial modulo unit dispatches one frame at a time, and a
// two-entry queue absorbs back-to-back frames.
// Synchronous active-high reset restores the control and configuration registers and
// empties the queue; the header byte store and dispatcher datapath are not cleared.
`default_nettype none
module packet_classify_and_worker_select_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pcws_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pcws_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data
);

   logic [4:0]   wc_ff;
   logic         ren_ff, pen_ff;
   logic [2:0]   sc_ff;
   logic [127:0] srv_ff;
   logic         job_valid, q_full, q_ne, q_pop;
   pcws_pkg::job_type job_in, job_head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff  <= 5'd1;
         ren_ff <= 1'b0;
         pen_ff <= 1'b0;
         sc_ff  <= '0;
         srv_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            pcws_pkg::CsrWorkerCount:  wc_ff  <= csr_data[4:0];
            pcws_pkg::CsrRadiusEnable: ren_ff <= csr_data[0];
            pcws_pkg::CsrPppoeEnable:  pen_ff <= csr_data[0];
            pcws_pkg::CsrServerCount:  sc_ff  <= csr_data[2:0];
            default: srv_ff[csr_index[1:0]*32 +: 32] <= csr_data;
         endcase
      end
   end

   pcws_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .worker_count(wc_ff), .radius_en(ren_ff), .pppoe_en(pen_ff),
      .server_count(sc_ff), .servers(srv_ff),
      .job_valid, .job_data(job_in), .job_full(q_full)
   );

   pcws_queue u_queue (
      .clock, .reset, .push(job_valid), .push_data(job_in),
      .full(q_full), .not_empty(q_ne), .head(job_head), .pop(q_pop)
   );

   pcws_back u_back (
      .clock, .reset, .job_ready(q_ne), .job(job_head), .job_pop(q_pop),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
`default_nettype wire
